/* src/prid_pkg.sv */
// Shared types and constants for the palette run-length image decoder.
// Used by prid_parse and palette_rle_image_decoder; depends on nothing.
`default_nettype none

package prid_pkg;

   // Request kinds carried on req_opcode
   localparam logic OP_STREAM  = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   // Item codes in the compressed stream
   localparam logic [7:0] ITEM_SINGLE = 8'd1;
   localparam logic [7:0] ITEM_FILL8  = 8'd2;
   localparam logic [7:0] ITEM_FILL16 = 8'd3;
   localparam logic [7:0] ITEM_FILL24 = 8'd4;
   localparam logic [7:0] ITEM_LIT8   = 8'd5;
   localparam logic [7:0] ITEM_LIT16  = 8'd6;
   localparam logic [7:0] ITEM_LIT24  = 8'd7;

   // Result status codes
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_BAD_ITEM   = 2'd1;
   localparam logic [1:0] STAT_ZERO_TOTAL = 2'd2;
   localparam logic [1:0] STAT_PAST_TOTAL = 2'd3;

   typedef enum logic [2:0] {
      PH_OPCODE,
      PH_LEN2,
      PH_LEN1,
      PH_LEN0,
      PH_INDEX,
      PH_LITERAL
   } phase_type;

   // What one stream byte produces, before the palette lookup
   typedef struct packed {
      logic        have;
      logic        use_color;
      logic [23:0] count;
      logic [1:0]  status;
      logic        image_end;
   } step_type;

   // One finished result
   typedef struct packed {
      logic [23:0] color;
      logic [23:0] count;
      logic [1:0]  status;
      logic        image_end;
   } rsp_type;

   // Palette entries hold r,g,b high to low; results carry b,g,r
   function automatic logic [23:0] swap_rb(input logic [23:0] c);
      return {c[7:0], c[15:8], c[23:16]};
   endfunction

endpackage

`default_nettype wire

/* src/prid_parse.sv */
// Stream parser for the palette run-length image decoder: item decode,
// run lengths, pixel accounting and error latch. Depends on prid_pkg.
`default_nettype none

module prid_parse #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int LENGTH_BITS     = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic [7:0]         stream_byte,
   input  wire logic               final_byte,
   input  wire logic [23:0]        pixel_total,
   output prid_pkg::step_type      step
);
   import prid_pkg::*;

   localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

   phase_type              phase_ff, phase_in, phase_step;
   logic [2:0]             code_ff, code_in;
   logic [23:0]            accum_ff, accum_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [24:0]            done_ff, done_in;
   logic                   err_ff, err_in;

   logic [23:0]            len_shift;
   logic [LENGTH_BITS-1:0] len_new;
   logic                   active;
   logic                   is_literal;
   logic                   pixel;
   logic [24:0]            done_next;
   logic                   err_step;

   assign len_shift  = {accum_ff[15:0], stream_byte};
   assign len_new    = len_shift[LENGTH_BITS-1:0];
   assign active     = !err_ff && (pixel_total != 24'd0);
   assign is_literal = (code_ff >= ITEM_LIT8[2:0]);

   // Next state
   always_comb begin
      phase_step = phase_ff;
      if (active) begin
         case (phase_ff)
            PH_OPCODE: begin
               if (stream_byte == ITEM_SINGLE) begin
                  phase_step = PH_INDEX;
               end else if (stream_byte == ITEM_FILL24 || stream_byte == ITEM_LIT24) begin
                  phase_step = PH_LEN2;
               end else if (stream_byte == ITEM_FILL16 || stream_byte == ITEM_LIT16) begin
                  phase_step = PH_LEN1;
               end else if (stream_byte == ITEM_FILL8 || stream_byte == ITEM_LIT8) begin
                  phase_step = PH_LEN0;
               end else begin
                  phase_step = PH_OPCODE;
               end
            end
            PH_LEN2:  phase_step = PH_LEN1;
            PH_LEN1:  phase_step = PH_LEN0;
            PH_LEN0: begin
               if (!is_literal) begin
                  phase_step = PH_INDEX;
               end else if (len_new == '0) begin
                  phase_step = PH_OPCODE;
               end else begin
                  phase_step = PH_LITERAL;
               end
            end
            PH_INDEX: phase_step = PH_OPCODE;
            PH_LITERAL: begin
               if (left_ff == LENGTH_BITS'(1)) begin
                  phase_step = PH_OPCODE;
               end
            end
            default:  phase_step = PH_OPCODE;
         endcase
      end
      phase_in = final_byte ? PH_OPCODE : phase_step;
   end

   // Outputs and datapath
   always_comb begin
      step      = '0;
      pixel     = 1'b0;
      err_step  = err_ff;
      code_in   = code_ff;
      accum_in  = accum_ff;
      left_in   = left_ff;
      done_in   = done_ff;
      done_next = '0;
      if (err_ff) begin
         // drop bytes until the final one
      end else if (pixel_total == 24'd0) begin
         step.have   = 1'b1;
         step.status = STAT_ZERO_TOTAL;
         err_step    = 1'b1;
      end else begin
         case (phase_ff)
            PH_OPCODE: begin
               accum_in = '0;
               code_in  = stream_byte[2:0];
               if (stream_byte == 8'd0 || stream_byte > ITEM_LIT24) begin
                  code_in     = '0;
                  step.have   = 1'b1;
                  step.status = STAT_BAD_ITEM;
                  err_step    = 1'b1;
               end
            end
            PH_LEN2, PH_LEN1: begin
               accum_in = len_shift;
            end
            PH_LEN0: begin
               accum_in = 24'(len_new);
               if (is_literal) begin
                  left_in = len_new;
               end
            end
            PH_INDEX: begin
               pixel          = 1'b1;
               step.use_color = ({1'b0, stream_byte} < ENTRY_LIMIT);
               step.count     = (code_ff == ITEM_SINGLE[2:0]) ? 24'd1 : accum_ff;
            end
            PH_LITERAL: begin
               pixel          = 1'b1;
               step.use_color = ({1'b0, stream_byte} < ENTRY_LIMIT);
               step.count     = 24'd1;
               left_in        = left_ff - LENGTH_BITS'(1);
            end
            default: begin
            end
         endcase
         if (pixel) begin
            step.have = 1'b1;
            done_next = done_ff + {1'b0, step.count};
            if (done_next > {1'b0, pixel_total}) begin
               step.status = STAT_PAST_TOTAL;
               err_step    = 1'b1;
            end else begin
               done_in = done_next;
            end
         end
      end
      err_in = err_step;
      if (final_byte) begin
         // flag an item cut short, then clear for the next image
         if (!step.have && !err_step && phase_step != PH_OPCODE) begin
            step.status = STAT_BAD_ITEM;
         end
         step.have      = 1'b1;
         step.image_end = 1'b1;
         code_in        = '0;
         accum_in       = '0;
         left_in        = '0;
         done_in        = '0;
         err_in         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPCODE;
         code_ff  <= '0;
         accum_ff <= '0;
         left_ff  <= '0;
         done_ff  <= '0;
         err_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         done_ff  <= done_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

/* src/palette_rle_image_decoder.sv */
// Palette run-length image decoder: top level with the palette memory,
// lookup stage and result queue. Depends on prid_pkg and prid_parse.
//
// Usage:
//   req_* carries one item per transfer (req_valid high, req_stall low):
//   either a palette entry write (req_opcode = 1) or one compressed stream
//   byte (req_opcode = 0). rsp_* carries one result per transfer.
//   csr_we with csr_wdata sets the expected pixel total; write it only
//   while no transfer is in flight.
//   Throughput is one item per cycle while req_stall is low. A stream
//   byte is decoded in the cycle it is taken, its palette index is read
//   from the synchronous palette memory at that edge, and the result
//   passes through the lookup stage register into a four-entry result
//   queue, which drives rsp_valid. Palette writes give no result.
//   req_stall is a register-only function of the queue fill, so it rises
//   when three results are held or in flight; a stalled receiver thus
//   backs up into req_stall without losing or repeating results.
//   Reset clears the parser, the pixel total and the queue. The palette
//   memory is not cleared and must be written before its entries are used.
`default_nettype none

module palette_rle_image_decoder #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int LENGTH_BITS     = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [23:0] req_entry_color,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [23:0]      rsp_pixel_color,
   output logic [23:0]      rsp_repeat_count,
   output logic [1:0]       rsp_status,
   output logic             rsp_image_end,
   input  wire logic        csr_we,
   input  wire logic [23:0] csr_wdata
);
   import prid_pkg::*;

   localparam int         IDX_W       = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);
   localparam int         FIFO_DEPTH  = 4;
   localparam int         FIFO_PTR_W  = 2;
   localparam int         FIFO_CNT_W  = 3;

   logic [23:0]           total_ff;

   logic                  accept;
   logic                  stream_acc;
   logic                  pal_wr;
   step_type              step;

   logic [23:0]           palette_mem [PALETTE_ENTRIES];
   logic [23:0]           rd_ff;

   logic                  s1_valid_ff;
   step_type              s1_step_ff;
   rsp_type               s1_rsp;

   rsp_type               fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic [FIFO_CNT_W-1:0] fifo_load;
   logic                  rsp_pop;
   rsp_type               rsp_head;

   assign accept     = req_valid && !req_stall;
   assign stream_acc = accept && (req_opcode == OP_STREAM);
   assign pal_wr     = accept && (req_opcode == OP_PALETTE) &&
                       ({1'b0, req_entry_index} < ENTRY_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (csr_we) begin
         total_ff <= csr_wdata;
      end
   end

   prid_parse #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .LENGTH_BITS     (LENGTH_BITS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .step_en     (stream_acc),
      .stream_byte (req_stream_byte),
      .final_byte  (req_final_byte),
      .pixel_total (total_ff),
      .step        (step)
   );

   // Palette: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pal_wr) begin
         palette_mem[req_entry_index[IDX_W-1:0]] <= req_entry_color;
      end
      if (stream_acc) begin
         rd_ff <= palette_mem[req_stream_byte[IDX_W-1:0]];
      end
   end

   // Lookup stage: always drains into the queue the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= stream_acc && step.have;
      end
      if (stream_acc) begin
         s1_step_ff <= step;
      end
   end

   always_comb begin
      s1_rsp.color     = s1_step_ff.use_color ? swap_rb(rd_ff) : 24'd0;
      s1_rsp.count     = s1_step_ff.count;
      s1_rsp.status    = s1_step_ff.status;
      s1_rsp.image_end = s1_step_ff.image_end;
   end

   // Result queue
   assign rsp_valid   = (fifo_cnt_ff != '0);
   assign rsp_pop     = rsp_valid && !rsp_stall;
   assign fifo_load   = fifo_cnt_ff + FIFO_CNT_W'(s1_valid_ff);
   assign req_stall   = (fifo_load >= FIFO_CNT_W'(FIFO_DEPTH - 1));
   assign fifo_cnt_in = fifo_cnt_ff + FIFO_CNT_W'(s1_valid_ff) - FIFO_CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (s1_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         fifo_mem[wr_ptr_ff] <= s1_rsp;
      end
   end

   assign rsp_head         = fifo_mem[rd_ptr_ff];
   assign rsp_pixel_color  = rsp_head.color;
   assign rsp_repeat_count = rsp_head.count;
   assign rsp_status       = rsp_head.status;
   assign rsp_image_end    = rsp_head.image_end;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (fifo_cnt_ff < FIFO_CNT_W'(FIFO_DEPTH)) || rsp_pop)
      else $error("lookup stage pushed into a full queue");

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (stream_acc && req_final_byte) |=> (s1_valid_ff && s1_step_ff.image_end))
      else $error("final stream byte gave no image end result");

   a_palette_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_PALETTE) |=> !s1_valid_ff)
      else $error("palette write produced a result");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for palette_rle_image_decoder: directed and random images,
// checked against an in-bench decoder model. Depends on prid_pkg and the RTL.

module tb_top;
   import prid_pkg::*;

   localparam int IDLE_LIMIT = 1000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [7:0]  req_stream_byte;
   logic [7:0]  req_entry_index;
   logic [23:0] req_entry_color;
   logic        req_final_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [23:0] rsp_pixel_color;
   logic [23:0] rsp_repeat_count;
   logic [1:0]  rsp_status;
   logic        rsp_image_end;
   logic        csr_we;
   logic [23:0] csr_wdata;

   // decoder model state
   phase_type   dec_phase;
   logic [7:0]  dec_code;
   logic [23:0] dec_len;
   logic [23:0] dec_left;
   logic [24:0] dec_done;
   bit          dec_err;
   logic [23:0] pix_total;
   logic [23:0] pal_color [256];
   bit          pal_written [256];
   logic [7:0]  written_idx [$];

   rsp_type     expected_pixels [$];
   rsp_type     want_pixel;

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  items_sent = 0;
   int  images_done = 0;
   int  idle_cycles = 0;
   int  hold_request = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_gaps_on = 1'b1;

   palette_rle_image_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_stream_byte  (req_stream_byte),
      .req_entry_index  (req_entry_index),
      .req_entry_color  (req_entry_color),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_status       (rsp_status),
      .rsp_image_end    (rsp_image_end),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic void clear_decoder();
      dec_phase = PH_OPCODE;
      dec_code  = '0;
      dec_len   = '0;
      dec_left  = '0;
      dec_done  = '0;
      dec_err   = 1'b0;
   endfunction

   // True when the next stream byte is taken as a palette index
   function automatic bit palette_read_due();
      return !dec_err && pix_total != 0 && (dec_phase == PH_INDEX || dec_phase == PH_LITERAL);
   endfunction

   function automatic logic [23:0] lookup_color(input logic [7:0] idx);
      logic [23:0] e;
      e = pal_color[idx];
      return {e[7:0], e[15:8], e[23:16]};
   endfunction

   function automatic void decode_stream_byte(input logic [7:0] b, input logic fin);
      logic [23:0] color;
      logic [23:0] count;
      logic [1:0]  status;
      logic        have;
      logic        pixel;
      logic [24:0] next_done;
      color  = '0;
      count  = '0;
      status = STAT_OK;
      have   = 1'b0;
      pixel  = 1'b0;
      if (dec_err) begin
         // drop until the final byte
      end else if (pix_total == 0) begin
         status  = STAT_ZERO_TOTAL;
         have    = 1'b1;
         dec_err = 1'b1;
      end else begin
         case (dec_phase)
            PH_OPCODE: begin
               dec_len  = '0;
               dec_code = {5'b0, b[2:0]};
               case (b)
                  ITEM_SINGLE:             dec_phase = PH_INDEX;
                  ITEM_FILL24, ITEM_LIT24: dec_phase = PH_LEN2;
                  ITEM_FILL16, ITEM_LIT16: dec_phase = PH_LEN1;
                  ITEM_FILL8, ITEM_LIT8:   dec_phase = PH_LEN0;
                  default: begin
                     dec_code = '0;
                     status   = STAT_BAD_ITEM;
                     have     = 1'b1;
                     dec_err  = 1'b1;
                  end
               endcase
            end
            PH_LEN2: begin
               dec_len   = {dec_len[15:0], b};
               dec_phase = PH_LEN1;
            end
            PH_LEN1: begin
               dec_len   = {dec_len[15:0], b};
               dec_phase = PH_LEN0;
            end
            PH_LEN0: begin
               dec_len = {dec_len[15:0], b};
               if (dec_code >= ITEM_LIT8) begin
                  dec_left  = dec_len;
                  dec_phase = (dec_left == 0) ? PH_OPCODE : PH_LITERAL;
               end else begin
                  dec_phase = PH_INDEX;
               end
            end
            PH_INDEX: begin
               count     = (dec_code == ITEM_SINGLE) ? 24'd1 : dec_len;
               color     = lookup_color(b);
               pixel     = 1'b1;
               dec_phase = PH_OPCODE;
            end
            PH_LITERAL: begin
               count    = 24'd1;
               color    = lookup_color(b);
               pixel    = 1'b1;
               dec_left = dec_left - 24'd1;
               if (dec_left == 0)
                  dec_phase = PH_OPCODE;
            end
            default: dec_phase = PH_OPCODE;
         endcase
         if (pixel) begin
            next_done = dec_done + count;
            have = 1'b1;
            if (next_done > {1'b0, pix_total}) begin
               status  = STAT_PAST_TOTAL;
               dec_err = 1'b1;
            end else begin
               dec_done = next_done;
            end
         end
      end
      if (fin) begin
         // an item cut short by the final byte is flagged unless an error came first
         if (!have && !dec_err && dec_phase != PH_OPCODE)
            status = STAT_BAD_ITEM;
         have = 1'b1;
         clear_decoder();
      end
      if (have)
         expected_pixels.push_back('{color: color, count: count, status: status,
                                     image_end: fin});
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_item(input logic op, input logic [7:0] sbyte, input logic [7:0] eidx,
                            input logic [23:0] ecolor, input logic fin);
      logic [7:0] b;
      b = sbyte;
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      // never look up an entry that has not been written
      if (op == OP_STREAM && palette_read_due() && !pal_written[b])
         b = written_idx[$urandom_range(0, written_idx.size() - 1)];
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_stream_byte <= b;
      req_entry_index <= eidx;
      req_entry_color <= ecolor;
      req_final_byte  <= fin;
      if (op == OP_PALETTE) begin
         pal_color[eidx] = ecolor;
         if (!pal_written[eidx]) begin
            pal_written[eidx] = 1'b1;
            written_idx.push_back(eidx);
         end
      end else begin
         decode_stream_byte(b, fin);
      end
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_stream(input logic [7:0] b, input logic fin);
      send_item(OP_STREAM, b, 8'($urandom_range(0, 255)), 24'($urandom), fin);
   endtask

   task automatic send_palette(input logic [7:0] idx, input logic [23:0] color);
      send_item(OP_PALETTE, 8'($urandom_range(0, 255)), idx, color, 1'($urandom_range(0, 1)));
   endtask

   // Drop valid, drain all results and let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_total(input logic [23:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      pix_total = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
      if (got !== want) begin
         $display("%0d ns: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_pixels.size() == 0) begin
            $display("%0d ns: result color %h count %h status %h end %b with none expected",
                     $time, rsp_pixel_color, rsp_repeat_count, rsp_status, rsp_image_end);
            mismatch_count++;
         end else begin
            want_pixel = expected_pixels.pop_front();
            report_field("pixel_color", want_pixel.color, rsp_pixel_color);
            report_field("repeat_count", want_pixel.count, rsp_repeat_count);
            report_field("status", 24'(want_pixel.status), 24'(rsp_status));
            report_field("image_end", 24'(want_pixel.image_end), 24'(rsp_image_end));
         end
      end
   end

   // Receiver: random stall bursts, plus a long hold-off on request
   initial begin : receiver
      int hold_left;
      int burst_left;
      hold_left  = 0;
      burst_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gaps_on && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0d ns: no transfer for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, expected_pixels.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // Reset leaves the total at zero: the first stream byte of each image flags it
   task automatic test_zero_total();
      send_palette(8'h00, 24'h000000);
      send_palette(8'hFF, 24'hFFFFFF);
      send_palette(8'h5A, 24'h123456);
      send_palette(8'hA5, 24'hFEDCBA);
      send_stream(ITEM_SINGLE, 1'b0);
      send_stream(8'h00, 1'b0);
      send_stream(8'hFF, 1'b1);
      send_stream(ITEM_FILL8, 1'b1);
   endtask

   task automatic test_item_codes();
      set_total(24'hFFFFFF);
      send_stream(ITEM_SINGLE, 1'b0);
      send_stream(8'h00, 1'b0);
      send_stream(ITEM_SINGLE, 1'b0);
      send_stream(8'hFF, 1'b0);
      send_stream(ITEM_FILL8, 1'b0);       // zero-length fill
      send_stream(8'h00, 1'b0);
      send_stream(8'h5A, 1'b0);
      send_stream(ITEM_FILL16, 1'b0);
      send_stream(8'hFF, 1'b0);
      send_stream(8'hFF, 1'b0);
      send_stream(8'hA5, 1'b0);
      send_stream(ITEM_LIT8, 1'b0);
      send_stream(8'h02, 1'b0);
      send_stream(8'hA5, 1'b0);
      send_stream(8'h5A, 1'b0);
      send_stream(ITEM_LIT16, 1'b0);       // zero-length literal
      send_stream(8'h00, 1'b0);
      send_stream(8'h00, 1'b0);
      send_stream(ITEM_LIT24, 1'b0);
      send_stream(8'h00, 1'b0);
      send_stream(8'h00, 1'b0);
      send_stream(8'h01, 1'b0);
      send_stream(8'hFF, 1'b0);
      // full 24-bit run overruns the total
      send_stream(ITEM_FILL24, 1'b0);
      send_stream(8'hFF, 1'b0);
      send_stream(8'hFF, 1'b0);
      send_stream(8'hFF, 1'b0);
      send_stream(8'h00, 1'b0);
      send_stream(ITEM_LIT24, 1'b0);
      send_stream(8'h00, 1'b1);
   endtask

   task automatic test_error_cases();
      send_stream(8'h00, 1'b0);            // unknown code, latched
      send_stream(ITEM_SINGLE, 1'b0);
      send_stream(8'h00, 1'b1);
      send_stream(8'hFF, 1'b1);
      send_stream(ITEM_FILL16, 1'b0);      // cut short by the final byte
      send_stream(8'h12, 1'b1);
      send_stream(ITEM_LIT8, 1'b0);
      send_stream(8'h00, 1'b1);
      send_stream(ITEM_SINGLE, 1'b0);
      send_stream(8'h5A, 1'b1);
      set_total(24'd1);
      send_stream(ITEM_SINGLE, 1'b0);
      send_stream(8'hA5, 1'b0);
      send_stream(ITEM_SINGLE, 1'b0);
      send_stream(8'hFF, 1'b0);
      send_stream(8'h00, 1'b1);
   endtask

   // Hold the receiver off while the sender keeps offering pixels
   task automatic test_output_backpressure();
      set_total(24'hFFFFFF);
      req_gaps_on  = 1'b0;
      hold_request = 80;
      repeat (24) begin
         send_stream(ITEM_SINGLE, 1'b0);
         send_stream(8'($urandom_range(0, 255)), 1'b0);
      end
      send_stream(ITEM_SINGLE, 1'b0);
      send_stream(8'($urandom_range(0, 255)), 1'b1);
      req_gaps_on = 1'b1;
   endtask

   task automatic run_random_image();
      logic [7:0]  image_bytes [$];
      longint      pixel_sum;
      longint      cap;
      int          style;
      int          kind;
      int          nlen;
      int          len;
      int          k;
      int          j;
      logic [7:0]  code;
      logic [23:0] total;
      pixel_sum = 0;
      style = $urandom_range(0, 19);
      if (style < 2) begin
         // noise: mostly small codes, some arbitrary bytes
         repeat ($urandom_range(1, 12))
            image_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 8)));
      end else begin
         for (k = 0; k < $urandom_range(1, 8); k++) begin
            kind = $urandom_range(0, 2);
            if (kind == 0) begin
               image_bytes.push_back(ITEM_SINGLE);
               image_bytes.push_back(8'($urandom_range(0, 255)));
               pixel_sum += 1;
            end else begin
               nlen = $urandom_range(1, 3);
               if (kind == 1) begin
                  code = ITEM_FILL8 + 8'(nlen - 1);
                  case ($urandom_range(0, 3))
                     0:       len = 0;
                     1:       len = $urandom_range(1, 20);
                     default: len = $urandom_range(0, (1 << (8 * nlen)) - 1);
                  endcase
               end else begin
                  // keep literal runs short, they cost one byte per pixel
                  code = ITEM_LIT8 + 8'(nlen - 1);
                  len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
               end
               image_bytes.push_back(code);
               for (j = nlen - 1; j >= 0; j--)
                  image_bytes.push_back(8'(len >> (8 * j)));
               if (kind == 1)
                  image_bytes.push_back(8'($urandom_range(0, 255)));
               else
                  repeat (len) image_bytes.push_back(8'($urandom_range(0, 255)));
               pixel_sum += len;
            end
         end
         if (style < 4 && image_bytes.size() > 1) begin
            k = $urandom_range(1, image_bytes.size() - 1);
            while (image_bytes.size() > k)
               void'(image_bytes.pop_back());
         end
      end

      cap = (pixel_sum > 64'hFFFFFF) ? 64'hFFFFFF : pixel_sum;
      case ($urandom_range(0, 19))
         0:       total = '0;
         1, 2, 3: total = (cap > 0) ? 24'($urandom_range(0, 32'(cap - 1))) : 24'd1;
         4, 5:    total = 24'hFFFFFF;
         6:       total = 24'($urandom);
         default: total = (cap > 0) ? 24'(cap) : 24'd1;
      endcase

      repeat ($urandom_range(0, 3))
         send_palette(8'($urandom_range(0, 255)), 24'($urandom));
      set_total(total);
      for (k = 0; k < image_bytes.size(); k++) begin
         if ($urandom_range(0, 15) == 0)
            send_palette(8'($urandom_range(0, 255)), 24'($urandom));
         send_stream(image_bytes[k], k == image_bytes.size() - 1);
      end
      images_done++;
   endtask

   task automatic test_random_images(input int item_target, input bit with_gaps);
      req_gaps_on = with_gaps;
      rsp_gaps_on = with_gaps;
      while (items_sent < item_target)
         run_random_image();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_STREAM;
      req_stream_byte = '0;
      req_entry_index = '0;
      req_entry_color = '0;
      req_final_byte  = 1'b0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      clear_decoder();
      pix_total = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_zero_total();
      test_item_codes();
      test_error_cases();
      test_output_backpressure();
      test_random_images(1450, 1'b1);
      test_random_images(1700, 1'b0);

      settle();
      repeat (8) @(negedge clock);
      $display("Sent %0d items (%0d random images), checked %0d results, %0d mismatches.",
               items_sent, images_done, results_checked, mismatch_count);
      $display("Covered fills, literals, singles, bad codes, truncation, zero and past totals.");
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* sim.f */
src/prid_pkg.sv
src/prid_parse.sv
src/palette_rle_image_decoder.sv
bench/tb_top.sv
